### src/integer_gcd_unit_top_macros.svh
// Assertion helpers for the gcd unit; sampled on clk, idle while rst_n is low.
`ifndef INTEGER_GCD_UNIT_TOP_MACROS_SVH
`define INTEGER_GCD_UNIT_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IGCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IGCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/igcd_pkg.sv
package igcd_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int SHIFT_WIDTH = $clog2(DATA_WIDTH);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] first_operand;
        logic signed [DATA_WIDTH-1:0] second_operand;
    } operand_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] divisor;
        logic                  zero_operand;
    } result_t;

    typedef enum logic [2:0] {
        OP_HOLD       = 3'd0,
        OP_LOAD       = 3'd1,
        OP_HALVE_BOTH = 3'd2,
        OP_HALVE_A    = 3'd3,
        OP_HALVE_B    = 3'd4,
        OP_SUB        = 3'd5,
        OP_FINISH     = 3'd6
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic a_even;
        logic b_even;
    } dp_status_t;

endpackage

### src/igcd_dp.sv
module igcd_dp (
    input  logic                clk,
    input  igcd_pkg::dp_cmd_t   cmd,
    input  igcd_pkg::operand_t  operands,
    output igcd_pkg::dp_status_t status,
    output igcd_pkg::result_t   result
);
    import igcd_pkg::*;

    logic [DATA_WIDTH-1:0]  a_reg, a_next;
    logic [DATA_WIDTH-1:0]  b_reg, b_next;
    logic [SHIFT_WIDTH-1:0] k_reg, k_next;
    logic                   zflag_reg, zflag_next;
    result_t                result_reg, result_next;

    logic [DATA_WIDTH-1:0]  mag_a;
    logic [DATA_WIDTH-1:0]  mag_b;
    logic [DATA_WIDTH:0]    diff;

    // Two's complement magnitude; the most negative value maps to 2^(W-1).
    assign mag_a = operands.first_operand[DATA_WIDTH-1]
                 ? (~operands.first_operand + 1'b1) : operands.first_operand;
    assign mag_b = operands.second_operand[DATA_WIDTH-1]
                 ? (~operands.second_operand + 1'b1) : operands.second_operand;

    assign diff = {1'b0, a_reg} - {1'b0, b_reg};

    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        zflag_next  = zflag_reg;
        result_next = result_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                a_next     = mag_a;
                b_next     = mag_b;
                k_next     = '0;
                zflag_next = (mag_a == '0) || (mag_b == '0);
            end
            OP_HALVE_BOTH:
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            OP_HALVE_A:
            begin
                a_next = a_reg >> 1;
            end
            OP_HALVE_B:
            begin
                b_next = b_reg >> 1;
            end
            OP_SUB:
            begin
                // Both odd: replace the larger by the difference.
                if (!diff[DATA_WIDTH])
                begin
                    a_next = diff[DATA_WIDTH-1:0];
                end
                else
                begin
                    b_next = b_reg - a_reg;
                end
            end
            OP_FINISH:
            begin
                result_next.divisor      = (a_reg | b_reg) << k_reg;
                result_next.zero_operand = zflag_reg;
            end
            default:
            begin
                a_next = a_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        zflag_reg  <= zflag_next;
        result_reg <= result_next;
    end

    assign status.a_zero = (a_reg == '0);
    assign status.b_zero = (b_reg == '0);
    assign status.a_even = ~a_reg[0];
    assign status.b_even = ~b_reg[0];
    assign result        = result_reg;

endmodule

### src/igcd_ctrl.sv
module igcd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  igcd_pkg::dp_status_t status,
    output igcd_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import igcd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_HOLD;
        case (state_reg)
            S_IDLE, S_OUT:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_RUN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RUN:
            begin
                if (status.a_zero || status.b_zero)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_OUT;
                end
                else if (status.a_even && status.b_even)
                begin
                    cmd.op = OP_HALVE_BOTH;
                end
                else if (status.a_even)
                begin
                    cmd.op = OP_HALVE_A;
                end
                else if (status.b_even)
                begin
                    cmd.op = OP_HALVE_B;
                end
                else
                begin
                    cmd.op = OP_SUB;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == S_RUN);
    assign done = (state_reg == S_OUT);

endmodule

### src/integer_gcd_unit_top.sv
// Integer gcd unit: greatest common divisor of the magnitudes of two signed words.
//
// Input channel: drive operands and raise start; the beat is taken at the clock
// edge where start is high and busy is low. busy stays high while a beat is in work.
// Output channel: done is high for exactly one cycle and result is valid in that
// cycle only as far as the receiver is concerned; the receiver cannot stall, so
// sample it then.
//
// Method: binary (Stein) gcd on a shifter/subtractor datapath, one step a cycle:
// halve both while both are even (counting common factors of two), halve the even
// one, or subtract the smaller odd value from the larger. When one side hits zero
// the other side, shifted back by the common count, is the divisor.
// A zero operand gives the other magnitude with zero_operand set; two zeros give 0.
//
// Sequence: load the magnitudes, run the step loop until one side is zero, then
// register the result in a finish step and raise done. A new beat may be taken in
// the cycle done is high. Reset returns the controller to idle; no result is pending.
module integer_gcd_unit_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  igcd_pkg::operand_t operands,
    output logic               busy,
    output logic               done,
    output igcd_pkg::result_t  result
);
    import igcd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence the steps.
    igcd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Hold the working pair, the shift count and the result register.
    igcd_dp u_dp (
        .clk      (clk),
        .operands (operands),
        .cmd      (cmd),
        .status   (status),
        .result   (result)
    );

`include "integer_gcd_unit_top_macros.svh"

    `IGCD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not start work")
    `IGCD_ASSERT_NEXT(a_done_single, done, !done, "done held longer than one cycle")
    `IGCD_ASSERT_NOW(a_nonzero_gcd, done, (result.divisor != '0) || result.zero_operand,
        "zero divisor without a zero operand")
    `IGCD_ASSERT_NOW(a_done_not_busy, done, !busy, "done raised while still busy")

endmodule

### tb/tb_integer_gcd_unit_top.sv
module tb_integer_gcd_unit_top;

    import igcd_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_BEATS = 1300;
    // Worst-case step loop of the binary gcd, plus load and finish cycles.
    localparam int BEAT_LATENCY = 4 * DATA_WIDTH + 2;
    localparam int TAIL_CYCLES  = BEAT_LATENCY + 16;
    // Quiet cycles (no beat taken, no result) before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;
    // Window of taken beats in which the sender never idles at random; drain holds still apply.
    localparam int CALM_FIRST   = 500;
    localparam int CALM_LAST    = 800;

    localparam logic signed [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // One planned beat; drain_first holds it back until every result is home.
    typedef struct {
        operand_t ops;
        bit       drain_first;
    } beat_plan_t;

    logic     clk      = 1'b0;
    logic     rst_n    = 1'b0;
    logic     start    = 1'b0;
    operand_t operands = '0;
    logic     busy;
    logic     done;
    result_t  result;

    beat_plan_t pending_beats[$];
    result_t    expected_gcds[$];
    int         beats_taken    = 0;
    int         results_seen   = 0;
    int         mismatch_count = 0;

    integer_gcd_unit_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .operands (operands),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: gcd of the two magnitudes by Euclid's method. A zero
    // operand short-circuits to the other magnitude and raises the flag.
    // The most negative word negates to itself, which read unsigned is
    // exactly 2^(DATA_WIDTH-1).
    // ------------------------------------------------------------------
    function automatic result_t predict_gcd(operand_t ops);
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        logic [DATA_WIDTH-1:0] rem;
        result_t               res;
        a = ops.first_operand;
        b = ops.second_operand;
        if (a[DATA_WIDTH-1])
            a = ~a + 1'b1;
        if (b[DATA_WIDTH-1])
            b = ~b + 1'b1;
        if (a == '0 || b == '0)
        begin
            res.divisor      = a | b;
            res.zero_operand = 1'b1;
        end
        else
        begin
            while (b != '0)
            begin
                rem = a % b;
                a   = b;
                b   = rem;
            end
            res.divisor      = a;
            res.zero_operand = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [DATA_WIDTH-1:0] got,
                                   logic [DATA_WIDTH-1:0] want);
        $display("result %0d: %s got 0x%0h, want 0x%0h", results_seen, field, got, want);
        mismatch_count++;
    endtask

    task automatic queue_beat(logic signed [DATA_WIDTH-1:0] a,
                              logic signed [DATA_WIDTH-1:0] b, bit drain);
        beat_plan_t plan;
        plan.ops.first_operand  = a;
        plan.ops.second_operand = b;
        plan.drain_first        = drain;
        pending_beats.push_back(plan);
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] pick_extreme();
        logic signed [DATA_WIDTH-1:0] v;
        case ($urandom_range(4, 0))
            0:       v = MOST_NEG;
            1:       v = MOST_POS;
            2:       v = -1;
            3:       v = 1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Mix of shapes: raw words for bit coverage, pairs sharing a factor
    // (with powers of two mixed in) so the divisor is not almost always 1,
    // zero operands, extremes and small values.
    function automatic operand_t random_pair();
        operand_t    p;
        int unsigned kind;
        int unsigned common;
        kind = $urandom_range(99, 0);
        if (kind < 40)
        begin
            p.first_operand  = $urandom;
            p.second_operand = $urandom;
        end
        else if (kind < 72)
        begin
            common           = $urandom_range(4095, 1) << $urandom_range(8, 0);
            p.first_operand  = common * $urandom_range(1023, 1);
            p.second_operand = common * $urandom_range(1023, 1);
            if ($urandom_range(1, 0))
                p.first_operand = -p.first_operand;
            if ($urandom_range(1, 0))
                p.second_operand = -p.second_operand;
        end
        else if (kind < 80)
        begin
            p.first_operand  = $urandom_range(1, 0) ? pick_extreme() : $urandom;
            p.second_operand = $urandom_range(1, 0) ? pick_extreme() : $urandom;
            case ($urandom_range(2, 0))
                0:       p.first_operand  = '0;
                1:       p.second_operand = '0;
                default:
                begin
                    p.first_operand  = '0;
                    p.second_operand = '0;
                end
            endcase
        end
        else if (kind < 86)
        begin
            p.first_operand  = pick_extreme();
            p.second_operand = pick_extreme();
        end
        else
        begin
            p.first_operand  = $urandom_range(255, 0);
            p.second_operand = $urandom_range(255, 0);
            if ($urandom_range(1, 0))
                p.first_operand = -p.first_operand;
            if ($urandom_range(1, 0))
                p.second_operand = -p.second_operand;
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Driver: a beat is taken at the edge where start is high and busy is
    // low. On that edge, record the prediction and drop the beat from the
    // pending queue, then decide what to present for the next edge. Each
    // output gets at most one nonblocking assignment per edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_beats
        bit idle_now;
        bit hold_for_drain;
        if (!rst_n)
        begin
            start    <= 1'b0;
            operands <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_gcds.push_back(predict_gcd(operands));
                void'(pending_beats.pop_front());
                beats_taken++;
            end
            // Idle at random with a 6 percent chance, except inside the calm window.
            idle_now = (beats_taken < CALM_FIRST || beats_taken >= CALM_LAST) &&
                       ($urandom_range(99, 0) < 6);
            // Hold a drain beat until every outstanding result is back.
            hold_for_drain = pending_beats.size() != 0 && pending_beats[0].drain_first &&
                             expected_gcds.size() != 0;
            if (pending_beats.size() == 0 || idle_now || hold_for_drain)
            begin
                start <= 1'b0;
            end
            else
            begin
                start    <= 1'b1;
                operands <= pending_beats[0].ops;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: done marks a one-cycle result that cannot be held off, so
    // sample it on the edge that closes that cycle and compare it with the
    // oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (expected_gcds.size() == 0)
            begin
                report_mismatch("unexpected divisor", result.divisor, '0);
            end
            else
            begin
                want = expected_gcds.pop_front();
                if (result.divisor !== want.divisor)
                    report_mismatch("divisor", result.divisor, want.divisor);
                if (result.zero_operand !== want.zero_operand)
                    report_mismatch("zero_operand", DATA_WIDTH'(result.zero_operand),
                                    DATA_WIDTH'(want.zero_operand));
            end
            results_seen++;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no beat or result for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run. Directed beats cover the special cases:
    // both operands zero, one operand zero on either side, the most
    // negative word alone and paired, the largest word, sign mixes, and a
    // Fibonacci pair that drives the longest Euclid chain.
    // ------------------------------------------------------------------
    initial
    begin : run_test
        operand_t p;
        queue_beat(0, 0, 1'b0);
        queue_beat(0, 5, 1'b0);
        queue_beat(-7, 0, 1'b0);
        queue_beat(MOST_NEG, 0, 1'b0);
        queue_beat(0, MOST_NEG, 1'b0);
        queue_beat(0, MOST_POS, 1'b0);
        queue_beat(-1, 0, 1'b0);
        queue_beat(MOST_NEG, MOST_NEG, 1'b0);
        queue_beat(MOST_NEG, MOST_POS, 1'b0);
        queue_beat(MOST_POS, MOST_POS, 1'b0);
        queue_beat(MOST_POS, -MOST_POS, 1'b0);
        queue_beat(-1, -1, 1'b0);
        queue_beat(1, MOST_NEG, 1'b0);
        queue_beat(MOST_NEG, 32'sh4000_0000, 1'b0);
        queue_beat(MOST_POS, MOST_POS - 1, 1'b0);
        queue_beat(32'sd1836311903, 32'sd1134903170, 1'b0);
        queue_beat(-32'sd1134903170, 32'sd701408733, 1'b0);
        queue_beat(12, -18, 1'b0);
        queue_beat(-48, -36, 1'b0);
        queue_beat(32'sh0001_0000, 32'sh0000_0100, 1'b0);
        queue_beat(6, 6, 1'b0);
        queue_beat(MOST_NEG, -6, 1'b0);

        // Drain before the random part and every so often inside it.
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            p = random_pair();
            queue_beat(p.first_operand, p.second_operand, (i % 250) == 0);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || expected_gcds.size() != 0)
            @(posedge clk);
        // Let a stray late result show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/igcd_pkg.sv
src/igcd_dp.sv
src/igcd_ctrl.sv
src/integer_gcd_unit_top.sv
tb/tb_integer_gcd_unit_top.sv
